FILE: src/dcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_pkg
// Types, register codes and defaults of the decimating 2D filter.
// ----------------------------------------------------------------------------
package dcf_pkg;

	localparam int DEF_MAX_KERNEL    = 8;
	localparam int DEF_MAX_SRC_WIDTH = 2048;
	localparam int DEF_CHANNEL_BITS  = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int COL_W      = 13;
	localparam int ACC_W      = 38;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KSIZE       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_INTENS  = 2'd3;

	typedef struct packed {
		logic        func;
		logic [15:0] in_red;
		logic [15:0] in_green;
		logic [15:0] in_blue;
		logic [5:0]  coef_index;
		logic [15:0] coef_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic [9:0]  out_x;
		logic        row_end;
	} out_item_t;

	typedef struct packed {
		logic             wr_pix;
		logic             wr_coef;
		logic             tap_en;
		logic             tap_use;
		logic [2:0]       slot;
		logic [COL_W-1:0] col;
		logic [5:0]       kidx;
		logic             clr_acc;
		logic             load_out;
		logic [9:0]       out_x;
		logic             row_end;
		logic [15:0]      max_intens;
	} dp_cmd_t;

endpackage

FILE: src/dcf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_datapath
// Line store, weight store, three multiply-accumulate lanes and result register.
// ----------------------------------------------------------------------------
module dcf_datapath #(
	parameter int MAX_KERNEL    = dcf_pkg::DEF_MAX_KERNEL,
	parameter int MAX_SRC_WIDTH = dcf_pkg::DEF_MAX_SRC_WIDTH,
	parameter int CHANNEL_BITS  = dcf_pkg::DEF_CHANNEL_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dcf_pkg::dp_cmd_t   cmd,
	input  dcf_pkg::in_item_t  in_item,
	output logic               out_full,
	output logic               out_valid,
	input  logic               out_ready,
	output dcf_pkg::out_item_t out_item
);
	import dcf_pkg::*;

	localparam int DEPTH  = MAX_KERNEL * MAX_SRC_WIDTH;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OMAX   = (CHANNEL_BITS >= 16) ? 65535 : ((1 << CHANNEL_BITS) - 1);
	localparam logic [15:0] CH_MAX = 16'(OMAX);

	logic [47:0] line_mem [DEPTH];
	logic [15:0] coef_mem [64];

	logic [AW-1:0]    addr;
	logic [15:0]      cr, cg, cb;
	logic [47:0]      rd_s1;
	logic [15:0]      wt_s1;
	logic             use_s1;
	logic [31:0]      prod_s2 [3];
	logic [ACC_W-1:0] acc_q [3];
	logic [15:0]      res [3];
	logic             out_valid_q;
	out_item_t        out_q;

	assign addr = AW'(cmd.slot) * AW'(MAX_SRC_WIDTH) + AW'(cmd.col);

	assign cr = (in_item.in_red   > CH_MAX) ? CH_MAX : in_item.in_red;
	assign cg = (in_item.in_green > CH_MAX) ? CH_MAX : in_item.in_green;
	assign cb = (in_item.in_blue  > CH_MAX) ? CH_MAX : in_item.in_blue;

	always_ff @(posedge clk) begin
		if (cmd.wr_pix) begin
			line_mem[addr] <= {cb, cg, cr};
		end
		if (cmd.tap_en) begin
			rd_s1 <= line_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_coef) begin
			coef_mem[in_item.coef_index] <= in_item.coef_value;
		end
		if (cmd.tap_en) begin
			wt_s1 <= coef_mem[cmd.kidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_s1 <= 1'b0;
		end else begin
			use_s1 <= cmd.tap_en && cmd.tap_use;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			logic [15:0] v;
			v = rd_s1[16*i +: 16];
			if (cmd.max_intens != 16'd0 && v > cmd.max_intens) begin
				v = cmd.max_intens;
			end
			prod_s2[i] <= use_s1 ? (32'(v) * 32'(wt_s1)) : 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cmd.clr_acc) begin
				acc_q[i] <= '0;
			end else begin
				acc_q[i] <= acc_q[i] + ACC_W'(prod_s2[i]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [ACC_W-1:0] r;
			r = (acc_q[i] + ACC_W'(32'h8000)) >> 16;
			res[i] = (r > ACC_W'(OMAX)) ? CH_MAX : r[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.out_red   <= res[0];
			out_q.out_green <= res[1];
			out_q.out_blue  <= res[2];
			out_q.out_x     <= cmd.out_x;
			out_q.row_end   <= cmd.row_end;
		end
	end

	assign out_full  = out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: src/dcf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_ctrl
// Configuration registers, stream counters and the tap sequencer.
// ----------------------------------------------------------------------------
module dcf_ctrl #(
	parameter int MAX_KERNEL    = dcf_pkg::DEF_MAX_KERNEL,
	parameter int MAX_SRC_WIDTH = dcf_pkg::DEF_MAX_SRC_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dcf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dcf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic                               out_full,
	output dcf_pkg::dp_cmd_t                   cmd
);
	import dcf_pkg::*;

	localparam int CAP = (MAX_KERNEL < 8) ? MAX_KERNEL : 8;
	localparam logic [3:0] CAP4 = 4'(CAP);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [10:0]      out_width_q;
	logic [3:0]       factor_q, ksize_q;
	logic [15:0]      max_intens_q;
	logic [3:0]       eff_f, eff_k, f1;
	logic [10:0]      eff_w;
	logic [13:0]      src_w;
	logic [2:0]       head_q, row_ph_q, col_ph_q;
	logic [3:0]       rows_q;
	logic [COL_W-1:0] col_q;
	logic [9:0]       x_q;
	logic [2:0]       cur_head_q;
	logic [3:0]       cur_rows_q;
	logic [COL_W-1:0] cur_col_q;
	logic [9:0]       cur_x_q;
	logic             cur_end_q;
	logic [2:0]       ky_q, kx_q;
	logic             drain_q;
	logic             accept, pix, produce, col_last, last_tap;
	logic [3:0]       back;
	logic [4:0]       slot_sum;
	logic [2:0]       slot;
	logic [14:0]      t_col, s_col;
	logic             row_ok, col_ok;

	always_comb begin
		eff_f = (factor_q == 4'd0) ? 4'd1 : factor_q;
		if (eff_f > CAP4) eff_f = CAP4;
		eff_k = (ksize_q > CAP4) ? CAP4 : ksize_q;
		if (eff_k < eff_f) eff_k = eff_f;
		eff_w = (out_width_q == 11'd0) ? 11'd1 : out_width_q;
		if (eff_w > 11'd1024) eff_w = 11'd1024;
	end

	assign src_w    = 14'(eff_w) * 14'(eff_f);
	assign f1       = eff_f - 4'd1;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign pix      = accept && !func;
	assign produce  = ({1'b0, row_ph_q} == f1) && ({1'b0, col_ph_q} == f1);
	assign col_last = (14'(col_q) + 14'd1) >= src_w;
	assign last_tap = ({1'b0, kx_q} == eff_k - 4'd1) && ({1'b0, ky_q} == eff_k - 4'd1);

	always_comb begin
		back     = eff_k - 4'd1 - {1'b0, ky_q};
		row_ok   = back <= cur_rows_q;
		slot_sum = 5'(cur_head_q) + 5'(eff_k) - 5'(back);
		slot     = (slot_sum >= 5'(eff_k)) ? 3'(slot_sum - 5'(eff_k)) : slot_sum[2:0];
		t_col    = 15'(cur_col_q) + 15'd1 + 15'(kx_q);
		s_col    = t_col - 15'(eff_k);
		col_ok   = (t_col >= 15'(eff_k)) && (16'(s_col) < 16'(MAX_SRC_WIDTH));
	end

	always_comb begin
		cmd            = '0;
		cmd.max_intens = max_intens_q;
		cmd.out_x      = cur_x_q;
		cmd.row_end    = cur_end_q;
		cmd.kidx       = {ky_q, kx_q};
		case (state_q)
			S_IDLE: begin
				cmd.slot    = head_q;
				cmd.col     = col_q;
				cmd.wr_pix  = pix && (14'(col_q) < 14'(MAX_SRC_WIDTH));
				cmd.wr_coef = accept && func;
				cmd.clr_acc = pix && produce;
			end
			S_RUN: begin
				cmd.slot    = slot;
				cmd.col     = s_col[COL_W-1:0];
				cmd.tap_en  = 1'b1;
				cmd.tap_use = row_ok && col_ok;
			end
			S_DONE: begin
				cmd.load_out = !out_full;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= 11'd640;
			factor_q     <= 4'd2;
			ksize_q      <= 4'd4;
			max_intens_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OUT_WIDTH:   out_width_q  <= cfg_data[10:0];
				REG_FACTOR:      factor_q     <= cfg_data[3:0];
				REG_KSIZE:       ksize_q      <= cfg_data[3:0];
				REG_MAX_INTENS:  max_intens_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			rows_q   <= '0;
			col_q    <= '0;
			row_ph_q <= '0;
			col_ph_q <= '0;
			x_q      <= '0;
		end else if (cfg_we) begin
			head_q   <= '0;
			rows_q   <= '0;
			col_q    <= '0;
			row_ph_q <= '0;
			col_ph_q <= '0;
			x_q      <= '0;
		end else if (pix) begin
			if (col_last) begin
				col_q    <= '0;
				col_ph_q <= '0;
				x_q      <= '0;
				head_q   <= ({1'b0, head_q} == eff_k - 4'd1) ? 3'd0 : head_q + 3'd1;
				if (rows_q < eff_k) rows_q <= rows_q + 4'd1;
				row_ph_q <= ({1'b0, row_ph_q} == f1) ? 3'd0 : row_ph_q + 3'd1;
			end else begin
				col_q <= col_q + COL_W'(1);
				if ({1'b0, col_ph_q} == f1) begin
					col_ph_q <= '0;
					x_q      <= x_q + 10'd1;
				end else begin
					col_ph_q <= col_ph_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix) begin
			cur_head_q <= head_q;
			cur_rows_q <= rows_q;
			cur_col_q  <= col_q;
			cur_x_q    <= x_q;
			cur_end_q  <= (11'(x_q) == eff_w - 11'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ky_q    <= '0;
			kx_q    <= '0;
			drain_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pix && produce) begin
						state_q <= S_RUN;
						ky_q    <= '0;
						kx_q    <= '0;
					end
				end
				S_RUN: begin
					if (last_tap) begin
						state_q <= S_DRAIN;
						drain_q <= 1'b0;
					end else if ({1'b0, kx_q} == eff_k - 4'd1) begin
						kx_q <= '0;
						ky_q <= ky_q + 3'd1;
					end else begin
						kx_q <= kx_q + 3'd1;
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_full) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/decimating_2d_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimating_2d_filter
// A pixel that completes an output is taken, then each kernel tap is read,
// the product and accumulate registers drain and the result register loads
// once the last result has left; other items never hold the input off. Such
// a pixel holds it off throughout, at one tap a cycle on the line store read port.
// Reset clears control state and loads register defaults; stores are unset.
// ----------------------------------------------------------------------------
module decimating_2d_filter #(
	parameter int MAX_KERNEL    = dcf_pkg::DEF_MAX_KERNEL,
	parameter int MAX_SRC_WIDTH = dcf_pkg::DEF_MAX_SRC_WIDTH,
	parameter int CHANNEL_BITS  = dcf_pkg::DEF_CHANNEL_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  dcf_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output dcf_pkg::out_item_t             out_item
);
	import dcf_pkg::*;

	dp_cmd_t cmd;
	logic    out_full;

	dcf_ctrl #(
		.MAX_KERNEL   (MAX_KERNEL),
		.MAX_SRC_WIDTH(MAX_SRC_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (in_item.func),
		.out_full (out_full),
		.cmd      (cmd)
	);

	dcf_datapath #(
		.MAX_KERNEL   (MAX_KERNEL),
		.MAX_SRC_WIDTH(MAX_SRC_WIDTH),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.out_full (out_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule
